[rtl/wav_stream_parser_unit_assert.svh]
// Assertion macros shared by the WAV stream parser RTL.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef WAV_STREAM_PARSER_UNIT_ASSERT_SVH
`define WAV_STREAM_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("wsp assertion failed");

// Next-cycle implication, checked outside reset.
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("wsp assertion failed");

`endif

[rtl/wsp_pkg.sv]
// Package of the WAV stream parser: parse phases, status codes, result types.
// No dependencies; used by all modules.
`timescale 1ns / 1ps

package wsp_pkg;

	typedef enum logic [2:0] {
		PH_RIFF, PH_ID, PH_SIZE, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_IDLE
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK, ST_SHORT, ST_BAD_HDR, ST_SHORT_FMT, ST_TRUNC, ST_MISSING, ST_UNSUPP
	} status_t;

	localparam logic [31:0] TAG_FMT        = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA       = 32'h6461_7461;
	localparam logic [15:0] FMT_PCM        = 16'h0001;
	localparam logic [15:0] FMT_FLOAT      = 16'h0003;
	localparam logic [15:0] FMT_EXT        = 16'hFFFE;
	localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
	localparam logic [31:0] MIN_FMT_BYTES  = 32'd16;
	localparam logic [31:0] SIGN_FLIP      = 32'h8000_0000;
	localparam int          OUT_DEPTH_DEF  = 4;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic               sample_is_float;
		logic [15:0]        channel_index;
		logic               is_status;
		logic [2:0]         status_code;
		logic [15:0]        channel_count;
		logic [31:0]        rate_hz;
		logic [31:0]        frames_out;
		logic               last_result;
	} res_t;

	// Results produced by one accepted byte: count 0..2, first in r0.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	// Expected header byte at file offsets 0..3 ("RIFF") and 8..11 ("WAVE").
	function automatic logic [7:0] magic_byte(input logic [3:0] idx);
		logic [7:0] v;
		unique case (idx)
			4'd0:    v = 8'h52;
			4'd1:    v = 8'h49;
			4'd2:    v = 8'h46;
			4'd3:    v = 8'h46;
			4'd8:    v = 8'h57;
			4'd9:    v = 8'h41;
			4'd10:   v = 8'h56;
			4'd11:   v = 8'h45;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

[rtl/wsp_if.sv]
// Stream interfaces of the WAV stream parser: byte input and result output.
// Depends on wsp_pkg for nothing but shares its field widths.
`timescale 1ns / 1ps

interface wsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_file;
	modport source(output valid, byte_in, end_of_file, input ready);
	modport sink(input valid, byte_in, end_of_file, output ready);
endinterface

interface wsp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_value;
	logic               sample_is_float;
	logic [15:0]        channel_index;
	logic               is_status;
	logic [2:0]         status_code;
	logic [15:0]        channel_count;
	logic [31:0]        rate_hz;
	logic [31:0]        frames_out;
	logic               last_result;
	modport source(output valid, sample_value, sample_is_float, channel_index, is_status,
		status_code, channel_count, rate_hz, frames_out, last_result, input ready);
	modport sink(input valid, sample_value, sample_is_float, channel_index, is_status,
		status_code, channel_count, rate_hz, frames_out, last_result, output ready);
endinterface

[rtl/wsp_parser.sv]
// Parse engine: header check, chunk walk, fmt capture, sample assembly, status.
// Depends on wsp_pkg.
`timescale 1ns / 1ps

module wsp_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     byte_in,
	input  logic           end_of_file,
	output wsp_pkg::push_t push
);

	logic [31:0]      bytes_q, bytes_n;
	wsp_pkg::phase_t  phase_q, phase_n;
	logic [31:0]      tag_q, tag_n;
	logic [31:0]      rem_q, rem_n;
	logic             pad_q, pad_n;
	logic [15:0]      fmt_tag_q, fmt_tag_n;
	logic [15:0]      chans_q, chans_n;
	logic [31:0]      rate_q, rate_n;
	logic [15:0]      bits_q, bits_n;
	logic [19:0]      fb_q, fb_n;
	logic [31:0]      asm_q, asm_n;
	logic [1:0]       bis_q, bis_n;
	logic [15:0]      chan_q, chan_n;
	logic [31:0]      frame_q, frame_n;
	logic             done_q, done_n;
	wsp_pkg::status_t err_q, err_n;
	logic [4:0]       fpos_q, fpos_n;

	logic [31:0] pos, size_v, asm_v;
	logic [12:0] bps;
	logic [15:0] chan_inc;
	logic        bad, tail, emit, bad_fmt, is_float;
	wsp_pkg::status_t code;
	wsp_pkg::res_t    smp, sts;

	assign bps      = bits_q[15:3];
	assign is_float = fmt_tag_q == wsp_pkg::FMT_FLOAT;

	always_comb begin
		bytes_n = bytes_q; phase_n = phase_q; tag_n = tag_q; rem_n = rem_q; pad_n = pad_q;
		fmt_tag_n = fmt_tag_q; chans_n = chans_q; rate_n = rate_q; bits_n = bits_q;
		fb_n = fb_q; asm_n = asm_q; bis_n = bis_q; chan_n = chan_q; frame_n = frame_q;
		done_n = done_q; err_n = err_q; fpos_n = fpos_q;
		pos = bytes_q; bad = 1'b0; tail = 1'b0; emit = 1'b0; bad_fmt = 1'b0;
		size_v = '0; asm_v = '0; chan_inc = '0; code = wsp_pkg::ST_OK;
		smp = '0; sts = '0;

		if (bytes_q != '1) bytes_n = bytes_q + 32'd1;

		if (err_q == wsp_pkg::ST_OK) begin
			unique case (phase_q)
				wsp_pkg::PH_RIFF: begin
					if (pos < 32'd4 || (pos >= 32'd8 && pos < 32'd12))
						bad = byte_in != wsp_pkg::magic_byte(pos[3:0]);
					if (bad) begin
						err_n = wsp_pkg::ST_BAD_HDR; phase_n = wsp_pkg::PH_IDLE;
					end else if (pos >= 32'd11) begin
						phase_n = wsp_pkg::PH_ID; bis_n = '0; tag_n = '0;
					end
				end
				wsp_pkg::PH_ID: begin
					tag_n = {tag_q[23:0], byte_in};
					if (bis_q == 2'd3) begin
						bis_n = '0; rem_n = '0; phase_n = wsp_pkg::PH_SIZE;
					end else begin
						bis_n = bis_q + 2'd1;
					end
				end
				wsp_pkg::PH_SIZE: begin
					size_v = rem_q | ({24'd0, byte_in} << {bis_q, 3'b000});
					rem_n  = size_v;
					if (bis_q == 2'd3) begin
						// Chunk header complete: pick the body handler.
						pad_n = size_v[0];
						bis_n = '0;
						if (tag_q == wsp_pkg::TAG_FMT) begin
							if (size_v < wsp_pkg::MIN_FMT_BYTES) begin
								err_n = wsp_pkg::ST_SHORT_FMT; phase_n = wsp_pkg::PH_IDLE;
							end else begin
								fpos_n = '0; phase_n = wsp_pkg::PH_FMT;
							end
						end else if (tag_q == wsp_pkg::TAG_DATA) begin
							if (fmt_tag_q != wsp_pkg::FMT_PCM && !is_float &&
								fmt_tag_q != wsp_pkg::FMT_EXT)
								bad_fmt = 1'b1;
							else if (is_float)
								bad_fmt = bits_q != 16'd32;
							else
								bad_fmt = bits_q != 16'd8 && bits_q != 16'd16 &&
									bits_q != 16'd24 && bits_q != 16'd32;
							if (size_v == '0 || chans_q == '0 || rate_q == '0) begin
								err_n = wsp_pkg::ST_MISSING; phase_n = wsp_pkg::PH_IDLE;
							end else if (bad_fmt) begin
								err_n = wsp_pkg::ST_UNSUPP; phase_n = wsp_pkg::PH_IDLE;
							end else begin
								// bps is 1..4 here
								fb_n = {4'd0, chans_q} * {17'd0, bps[2:0]};
								asm_n = '0; chan_n = '0; frame_n = '0;
								phase_n = wsp_pkg::PH_DATA;
							end
						end else if (size_v == '0) begin
							phase_n = wsp_pkg::PH_ID; tag_n = '0;
						end else begin
							phase_n = wsp_pkg::PH_SKIP;
						end
					end else begin
						bis_n = bis_q + 2'd1;
					end
				end
				wsp_pkg::PH_FMT: begin
					unique case (fpos_q)
						5'd0:  fmt_tag_n[7:0]  = byte_in;
						5'd1:  fmt_tag_n[15:8] = byte_in;
						5'd2:  chans_n[7:0]    = byte_in;
						5'd3:  chans_n[15:8]   = byte_in;
						5'd4:  rate_n[7:0]     = byte_in;
						5'd5:  rate_n[15:8]    = byte_in;
						5'd6:  rate_n[23:16]   = byte_in;
						5'd7:  rate_n[31:24]   = byte_in;
						5'd14: bits_n[7:0]     = byte_in;
						5'd15: bits_n[15:8]    = byte_in;
						default: ;
					endcase
					if (fpos_q < 5'd16) fpos_n = fpos_q + 5'd1;
					rem_n = rem_q - 32'd1;
					if (rem_n == '0) begin
						phase_n = pad_q ? wsp_pkg::PH_PAD : wsp_pkg::PH_ID;
						bis_n = '0; tag_n = '0;
					end
				end
				wsp_pkg::PH_SKIP: begin
					rem_n = rem_q - 32'd1;
					if (rem_n == '0) begin
						phase_n = pad_q ? wsp_pkg::PH_PAD : wsp_pkg::PH_ID;
						bis_n = '0; tag_n = '0;
					end
				end
				wsp_pkg::PH_PAD: begin
					phase_n = wsp_pkg::PH_ID; bis_n = '0; tag_n = '0;
				end
				wsp_pkg::PH_DATA: begin
					// Drop a trailing partial frame.
					tail = chan_q == '0 && bis_q == '0 && rem_q < {12'd0, fb_q};
					if (!tail) begin
						asm_v = {byte_in, asm_q[31:8]};
						if ({11'd0, bis_q} + 13'd1 >= bps) begin
							emit = 1'b1;
							smp.sample_value    = (bits_q == 16'd8) ?
								(asm_v ^ wsp_pkg::SIGN_FLIP) : asm_v;
							smp.sample_is_float = is_float;
							smp.channel_index   = chan_q;
							smp.last_result     = !end_of_file;
							asm_n = '0; bis_n = '0;
							chan_inc = chan_q + 16'd1;
							if (chan_inc >= chans_q) begin
								chan_n = '0; frame_n = frame_q + 32'd1;
							end else begin
								chan_n = chan_inc;
							end
						end else begin
							asm_n = asm_v; bis_n = bis_q + 2'd1;
						end
					end
					rem_n = rem_q - 32'd1;
					if (rem_n == '0) begin
						done_n = 1'b1; phase_n = wsp_pkg::PH_IDLE;
					end
				end
				wsp_pkg::PH_IDLE: ;
			endcase
		end

		if (bytes_n < wsp_pkg::MIN_FILE_BYTES) code = wsp_pkg::ST_SHORT;
		else if (err_n != wsp_pkg::ST_OK)      code = err_n;
		else if (done_n)                       code = wsp_pkg::ST_OK;
		else if (phase_n == wsp_pkg::PH_DATA)  code = wsp_pkg::ST_TRUNC;
		else                                   code = wsp_pkg::ST_MISSING;
		sts.is_status     = 1'b1;
		sts.status_code   = code;
		sts.channel_count = chans_n;
		sts.rate_hz       = rate_n;
		sts.frames_out    = frame_n;
		sts.last_result   = 1'b1;

		push.n  = {1'b0, emit} + {1'b0, end_of_file};
		push.r0 = emit ? smp : sts;
		push.r1 = sts;
		if (!take) push.n = '0;

		// Status ends the file: restart from reset state.
		if (end_of_file) begin
			bytes_n = '0; phase_n = wsp_pkg::PH_RIFF; tag_n = '0; rem_n = '0; pad_n = 1'b0;
			fmt_tag_n = '0; chans_n = '0; rate_n = '0; bits_n = '0; fb_n = '0; asm_n = '0;
			bis_n = '0; chan_n = '0; frame_n = '0; done_n = 1'b0; err_n = wsp_pkg::ST_OK;
			fpos_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0; phase_q <= wsp_pkg::PH_RIFF; tag_q <= '0; rem_q <= '0; pad_q <= 1'b0;
			fmt_tag_q <= '0; chans_q <= '0; rate_q <= '0; bits_q <= '0; fb_q <= '0;
			asm_q <= '0; bis_q <= '0; chan_q <= '0; frame_q <= '0; done_q <= 1'b0;
			err_q <= wsp_pkg::ST_OK; fpos_q <= '0;
		end else if (take) begin
			bytes_q <= bytes_n; phase_q <= phase_n; tag_q <= tag_n; rem_q <= rem_n;
			pad_q <= pad_n; fmt_tag_q <= fmt_tag_n; chans_q <= chans_n; rate_q <= rate_n;
			bits_q <= bits_n; fb_q <= fb_n; asm_q <= asm_n; bis_q <= bis_n;
			chan_q <= chan_n; frame_q <= frame_n; done_q <= done_n; err_q <= err_n;
			fpos_q <= fpos_n;
		end
	end

endmodule

[rtl/wsp_out_fifo.sv]
// Result queue: takes up to two results per cycle, hands out one per cycle while popped.
// Depends on wsp_pkg.
`timescale 1ns / 1ps

module wsp_out_fifo #(
	parameter int DEPTH = wsp_pkg::OUT_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wsp_pkg::push_t               push,
	output logic                         room,
	input  logic                         pop,
	output wsp_pkg::res_t                head,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	wsp_pkg::res_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q, wr_nx;
	logic [CW-1:0]   cnt_q;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_nx = inc(wr_q);
	assign room  = cnt_q <= CW'(DEPTH - 2);
	assign head  = mem_q[rd_q];
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_q]  <= push.r0;
		if (push.n == 2'd2) mem_q[wr_nx] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push.n == 2'd1)      wr_q <= wr_nx;
			else if (push.n == 2'd2) wr_q <= inc(wr_nx);
			if (pop) rd_q <= inc(rd_q);
			cnt_q <= cnt_q + CW'(push.n) - CW'(pop);
		end
	end

endmodule

[rtl/wav_stream_parser_unit.sv]
// Top level of the WAV stream parser: byte input, parse engine, result queue.
// Depends on wsp_pkg, wsp_if, wsp_parser, wsp_out_fifo and the assertion header.
`timescale 1ns / 1ps

// Streams a RIFF/WAVE file one byte per input item and returns one result
// item per decoded sample of the first data chunk, then a status item on the
// byte marked end_of_file (that byte may also yield a sample first; only the
// status then has last_result set). The block accepts one byte every cycle
// while the queue has room: each byte is parsed by combinational logic and
// its results are written straight into a small result queue. Input ready
// drops only when the queue (OUT_DEPTH entries) cannot hold two more results,
// which happens only while the output side stalls. After the status item the
// parser is back in its reset state and the next byte starts a new file.
`include "wav_stream_parser_unit_assert.svh"

module wav_stream_parser_unit #(
	parameter int OUT_DEPTH = wsp_pkg::OUT_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wsp_in_if.sink    in_ch,
	wsp_out_if.source out_ch
);

	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic           take, room, pop;
	wsp_pkg::push_t push;
	wsp_pkg::res_t  head;
	logic [CW-1:0]  level;

	// Accept a byte whenever the queue has room for its worst case of two results.
	assign in_ch.ready = room;
	assign take        = in_ch.valid && room;
	assign pop         = out_ch.valid && out_ch.ready;

	wsp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.byte_in     (in_ch.byte_in),
		.end_of_file (in_ch.end_of_file),
		.push        (push)
	);

	wsp_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.pop    (pop),
		.head   (head),
		.level  (level)
	);

	// Drive the output channel from the queue head.
	assign out_ch.valid           = level != '0;
	assign out_ch.sample_value    = head.sample_value;
	assign out_ch.sample_is_float = head.sample_is_float;
	assign out_ch.channel_index   = head.channel_index;
	assign out_ch.is_status       = head.is_status;
	assign out_ch.status_code     = head.status_code;
	assign out_ch.channel_count   = head.channel_count;
	assign out_ch.rate_hz         = head.rate_hz;
	assign out_ch.frames_out      = head.frames_out;
	assign out_ch.last_result     = head.last_result;

	`WSP_ASSERT_NOW(a_level_bound, clk, arst_n, 1'b1, level <= CW'(OUT_DEPTH))
	`WSP_ASSERT_NOW(a_status_last, clk, arst_n, out_ch.valid && out_ch.is_status,
		out_ch.last_result)
	`WSP_ASSERT_NEXT(a_eof_result, clk, arst_n, take && in_ch.end_of_file, out_ch.valid)
	`WSP_ASSERT_NOW(a_no_overfill, clk, arst_n, push.n == 2'd2, level <= CW'(OUT_DEPTH - 2))

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench of wav_stream_parser_unit: streams WAV files byte by byte.
// Depends on wsp_pkg and the stream interfaces wsp_in_if / wsp_out_if of the RTL.
`timescale 1ns / 1ps

module testbench;
	import wsp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 600;

	typedef struct {
		logic [7:0] b;
		bit         eof;
		bit         drain;
	} file_byte_t;

	// One file recipe: fields of the fmt chunk, chunk sizes and damage to apply.
	typedef struct {
		logic [15:0] fmt;
		logic [15:0] ch;
		logic [31:0] rate;
		logic [15:0] bits;
		int          fmt_size;
		logic [31:0] data_size;
		int          data_len;
		bit          junk;
		int          trailing;
		int          corrupt_at;
		int          cut_at;
		int          want_status;
	} wav_recipe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wsp_in_if  in_ch ();
	wsp_out_if out_ch ();

	wav_stream_parser_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #10 clk = ~clk;

	file_byte_t byte_q[$];
	res_t       pending_res_q[$];
	int         file_status_q[$];

	int  mismatches = 0;
	int  samples_seen = 0;
	int  statuses_seen = 0;
	int  files_built = 0;
	int  cycles = 0;
	bit  quiet = 1'b0;

	// Shadow copy of the parser state, advanced on every accepted byte.
	logic [31:0] sh_bytes;
	phase_t      sh_phase;
	logic [31:0] sh_tag;
	logic [31:0] sh_remaining;
	logic        sh_pad;
	logic [15:0] sh_fmt;
	logic [15:0] sh_ch;
	logic [31:0] sh_rate;
	logic [15:0] sh_bits;
	logic [19:0] sh_frame_bytes;
	logic [31:0] sh_assembly;
	logic [1:0]  sh_byte_idx;
	logic [15:0] sh_chan;
	logic [31:0] sh_frames;
	logic        sh_done;
	status_t     sh_err;
	logic [4:0]  sh_fmt_pos;

	task automatic clear_parser_state();
		sh_bytes = '0; sh_phase = PH_RIFF; sh_tag = '0; sh_remaining = '0; sh_pad = 1'b0;
		sh_fmt = '0; sh_ch = '0; sh_rate = '0; sh_bits = '0; sh_frame_bytes = '0;
		sh_assembly = '0; sh_byte_idx = '0; sh_chan = '0; sh_frames = '0; sh_done = 1'b0;
		sh_err = ST_OK; sh_fmt_pos = '0;
	endtask

	// Close a chunk body: go to the pad byte when the size was odd.
	task automatic close_body();
		sh_phase = sh_pad ? PH_PAD : PH_ID;
		sh_byte_idx = '0;
		sh_tag = '0;
	endtask

	// Chunk header complete: pick the body handling and run the data checks.
	task automatic open_chunk();
		logic [12:0] bps;
		bps = sh_bits[15:3];
		sh_pad = sh_remaining[0];
		sh_byte_idx = '0;
		if (sh_tag == TAG_FMT) begin
			if (sh_remaining < MIN_FMT_BYTES) begin
				sh_err = ST_SHORT_FMT;
				sh_phase = PH_IDLE;
				return;
			end
			sh_fmt_pos = '0;
			sh_phase = PH_FMT;
		end else if (sh_tag == TAG_DATA) begin
			if (sh_remaining == 0 || sh_ch == 0 || sh_rate == 0)
				sh_err = ST_MISSING;
			else if (sh_fmt != FMT_PCM && sh_fmt != FMT_FLOAT && sh_fmt != FMT_EXT)
				sh_err = ST_UNSUPP;
			else if (bps == 0)
				sh_err = ST_UNSUPP;
			else if (sh_fmt == FMT_FLOAT && sh_bits != 16'd32)
				sh_err = ST_UNSUPP;
			else if (sh_fmt != FMT_FLOAT && !(sh_bits == 16'd8 || sh_bits == 16'd16 ||
					sh_bits == 16'd24 || sh_bits == 16'd32))
				sh_err = ST_UNSUPP;
			if (sh_err != ST_OK) begin
				sh_phase = PH_IDLE;
				return;
			end
			sh_frame_bytes = 20'(sh_ch) * 20'(bps);
			sh_assembly = '0;
			sh_chan = '0;
			sh_frames = '0;
			sh_phase = PH_DATA;
		end else if (sh_remaining == 0) begin
			sh_phase = PH_ID;
			sh_tag = '0;
		end else begin
			sh_phase = PH_SKIP;
		end
	endtask

	// Advance the shadow parser by one byte and queue the results it yields.
	task automatic predict_byte(input logic [7:0] b, input logic eof);
		logic [31:0] pos;
		logic [12:0] bps;
		bit          partial;
		bit          made_sample;
		res_t        r;
		status_t     code;
		pos = sh_bytes;
		made_sample = 1'b0;
		if (sh_bytes != 32'hFFFF_FFFF)
			sh_bytes = sh_bytes + 1;
		if (sh_err == ST_OK) begin
			case (sh_phase)
				PH_RIFF: begin
					if (pos < 4 && b != magic_byte(pos[3:0]))
						sh_err = ST_BAD_HDR;
					else if (pos >= 8 && pos < 12 && b != magic_byte(pos[3:0]))
						sh_err = ST_BAD_HDR;
					if (sh_err != ST_OK)
						sh_phase = PH_IDLE;
					else if (pos >= 11) begin
						sh_phase = PH_ID;
						sh_byte_idx = '0;
						sh_tag = '0;
					end
				end
				PH_ID: begin
					sh_tag = {sh_tag[23:0], b};
					if (sh_byte_idx == 2'd3) begin
						sh_byte_idx = '0;
						sh_remaining = '0;
						sh_phase = PH_SIZE;
					end else
						sh_byte_idx = sh_byte_idx + 1;
				end
				PH_SIZE: begin
					sh_remaining = sh_remaining | (32'(b) << (8 * sh_byte_idx));
					if (sh_byte_idx == 2'd3)
						open_chunk();
					else
						sh_byte_idx = sh_byte_idx + 1;
				end
				PH_FMT: begin
					case (sh_fmt_pos)
						5'd0:  sh_fmt[7:0] = b;
						5'd1:  sh_fmt[15:8] = b;
						5'd2:  sh_ch[7:0] = b;
						5'd3:  sh_ch[15:8] = b;
						5'd4:  sh_rate[7:0] = b;
						5'd5:  sh_rate[15:8] = b;
						5'd6:  sh_rate[23:16] = b;
						5'd7:  sh_rate[31:24] = b;
						5'd14: sh_bits[7:0] = b;
						5'd15: sh_bits[15:8] = b;
						default: ;
					endcase
					if (sh_fmt_pos < 16)
						sh_fmt_pos = sh_fmt_pos + 1;
					sh_remaining = sh_remaining - 1;
					if (sh_remaining == 0)
						close_body();
				end
				PH_SKIP: begin
					sh_remaining = sh_remaining - 1;
					if (sh_remaining == 0)
						close_body();
				end
				PH_PAD: begin
					sh_phase = PH_ID;
					sh_byte_idx = '0;
					sh_tag = '0;
				end
				PH_DATA: begin
					bps = sh_bits[15:3];
					partial = sh_chan == 0 && sh_byte_idx == 0 &&
						sh_remaining < 32'(sh_frame_bytes);
					if (!partial) begin
						sh_assembly = {b, sh_assembly[31:8]};
						if (int'(sh_byte_idx) + 1 >= int'(bps)) begin
							r = '0;
							r.sample_value = (sh_bits == 16'd8) ? sh_assembly ^ SIGN_FLIP
								: sh_assembly;
							r.sample_is_float = sh_fmt == FMT_FLOAT;
							r.channel_index = sh_chan;
							r.last_result = 1'b1;
							pending_res_q.push_back(r);
							made_sample = 1'b1;
							sh_assembly = '0;
							sh_byte_idx = '0;
							sh_chan = sh_chan + 1;
							if (sh_chan >= sh_ch) begin
								sh_chan = '0;
								sh_frames = sh_frames + 1;
							end
						end else
							sh_byte_idx = sh_byte_idx + 1;
					end
					sh_remaining = sh_remaining - 1;
					if (sh_remaining == 0) begin
						sh_done = 1'b1;
						sh_phase = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
		if (eof) begin
			if (sh_bytes < MIN_FILE_BYTES)
				code = ST_SHORT;
			else if (sh_err != ST_OK)
				code = sh_err;
			else if (sh_done)
				code = ST_OK;
			else if (sh_phase == PH_DATA)
				code = ST_TRUNC;
			else
				code = ST_MISSING;
			// A sample from the same byte is no longer the last result.
			if (made_sample)
				pending_res_q[$].last_result = 1'b0;
			r = '0;
			r.is_status = 1'b1;
			r.status_code = code;
			r.channel_count = sh_ch;
			r.rate_hz = sh_rate;
			r.frames_out = sh_frames;
			r.last_result = 1'b1;
			pending_res_q.push_back(r);
			clear_parser_state();
		end
	endtask

	// Lay out one WAV file from a recipe, damage it as asked, queue its bytes.
	task automatic queue_file(input wav_recipe_t w, input bit drain);
		logic [7:0] f[$];
		file_byte_t fb;
		logic [31:0] riff_size;
		riff_size = $urandom;
		f = '{8'h52, 8'h49, 8'h46, 8'h46};
		for (int i = 0; i < 4; i++) f.push_back(riff_size[8*i +: 8]);
		f.push_back(8'h57); f.push_back(8'h41); f.push_back(8'h56); f.push_back(8'h45);
		if (w.junk) begin
			// Odd-sized chunk that must be skipped together with its pad byte.
			f.push_back("L"); f.push_back("I"); f.push_back("S"); f.push_back("T");
			f.push_back(8'd3); f.push_back(8'd0); f.push_back(8'd0); f.push_back(8'd0);
			for (int i = 0; i < 4; i++) f.push_back(8'($urandom));
		end
		f.push_back("f"); f.push_back("m"); f.push_back("t"); f.push_back(" ");
		for (int i = 0; i < 4; i++) f.push_back(8'(w.fmt_size >> (8 * i)));
		for (int i = 0; i < w.fmt_size; i++) begin
			case (i)
				0, 1:          f.push_back(w.fmt[8*i +: 8]);
				2, 3:          f.push_back(w.ch[8*(i-2) +: 8]);
				4, 5, 6, 7:    f.push_back(w.rate[8*(i-4) +: 8]);
				14, 15:        f.push_back(w.bits[8*(i-14) +: 8]);
				default:       f.push_back(8'($urandom));
			endcase
		end
		f.push_back("d"); f.push_back("a"); f.push_back("t"); f.push_back("a");
		for (int i = 0; i < 4; i++) f.push_back(w.data_size[8*i +: 8]);
		for (int i = 0; i < w.data_len; i++) f.push_back(8'($urandom));
		for (int i = 0; i < w.trailing; i++) f.push_back(8'($urandom));
		if (w.corrupt_at >= 0 && w.corrupt_at < f.size())
			f[w.corrupt_at] = f[w.corrupt_at] ^ 8'(1 + $urandom_range(0, 254));
		if (w.cut_at > 0 && w.cut_at < f.size())
			f = f[0 : w.cut_at - 1];
		foreach (f[i]) begin
			fb.b = f[i];
			fb.eof = (i == f.size() - 1);
			fb.drain = drain && (i == 0);
			byte_q.push_back(fb);
		end
		file_status_q.push_back(w.want_status);
		files_built++;
	endtask

	// Directed files: every status code, every sample width, extremes of the fields.
	// Columns: fmt, ch, rate, bits, fmt size, data size, data bytes, junk, trailing,
	// corrupt offset, cut length, status read off at a glance (-1: predictor only).
	wav_recipe_t directed_files[] = '{
		'{FMT_PCM,   16'd2,     32'd44100,     16'd16, 16, 32'd8,  8,  0, 0,  -1, 0,  ST_OK},
		'{FMT_PCM,   16'd1,     32'd8000,      16'd8,  16, 32'd5,  5,  1, 0,  -1, 0,  ST_OK},
		'{FMT_EXT,   16'd1,     32'd48000,     16'd24, 18, 32'd6,  6,  1, 0,  -1, 0,  ST_OK},
		'{FMT_PCM,   16'd1,     32'hFFFF_FFFF, 16'd32, 16, 32'd8,  8,  0, 0,  -1, 0,  ST_OK},
		'{FMT_FLOAT, 16'd2,     32'd96000,     16'd32, 16, 32'd8,  8,  0, 0,  -1, 0,  ST_OK},
		'{FMT_FLOAT, 16'd1,     32'd48000,     16'd64, 16, 32'd8,  8,  0, 0,  -1, 0,  ST_UNSUPP},
		'{FMT_PCM,   16'd1,     32'd22050,     16'd12, 16, 32'd4,  4,  0, 0,  -1, 0,  ST_UNSUPP},
		'{16'h0002,  16'd1,     32'd22050,     16'd16, 16, 32'd4,  4,  0, 0,  -1, 0,  ST_UNSUPP},
		'{FMT_PCM,   16'd0,     32'd22050,     16'd16, 16, 32'd4,  4,  0, 0,  -1, 0,  ST_MISSING},
		'{FMT_PCM,   16'd1,     32'd0,         16'd16, 16, 32'd4,  4,  0, 0,  -1, 0,  ST_MISSING},
		'{FMT_PCM,   16'd1,     32'd8000,      16'd16, 16, 32'd0,  0,  0, 4,  -1, 0,  ST_MISSING},
		'{FMT_PCM,   16'd1,     32'd8000,      16'd16, 14, 32'd4,  4,  0, 0,  -1, 0,  ST_SHORT_FMT},
		'{FMT_PCM,   16'd1,     32'd8000,      16'd16, 16, 32'd4,  4,  0, 0,  1,  0,  ST_BAD_HDR},
		'{FMT_PCM,   16'd1,     32'd8000,      16'd16, 16, 32'd4,  4,  0, 0,  9,  0,  ST_BAD_HDR},
		'{FMT_PCM,   16'd1,     32'd8000,      16'd16, 16, 32'd4,  4,  0, 0,  -1, 20, ST_SHORT},
		'{FMT_PCM,   16'd1,     32'd8000,      16'd16, 16, 32'd20, 6,  0, 0,  -1, 0,  ST_TRUNC},
		'{FMT_PCM,   16'd1,     32'd8000,      16'd16, 16, 32'd4,  4,  1, 0,  -1, 48, ST_MISSING},
		'{FMT_PCM,   16'd2,     32'd8000,      16'd16, 16, 32'd10, 10, 0, 0,  -1, 0,  ST_OK},
		'{FMT_PCM,   16'hFFFF,  32'd8000,      16'd8,  16, 32'd4,  4,  0, 0,  -1, 0,  ST_OK},
		'{FMT_PCM,   16'd1,     32'd8000,      16'd8,  16, 32'd5,  5,  0, 0,  -1, 0,  ST_OK},
		'{FMT_EXT,   16'd1,     32'd8000,      16'd16, 16, 32'd4,  4,  0, 12, -1, 0,  ST_OK}
	};

	task automatic queue_random_file(input bit drain);
		wav_recipe_t w;
		file_byte_t  fb;
		int          n;
		if ($urandom_range(0, 9) == 0) begin
			// Noise, sometimes behind a valid RIFF tag.
			n = $urandom_range(1, 60);
			for (int i = 0; i < n; i++) begin
				fb.b = (i < 4 && $urandom_range(0, 1)) ? magic_byte(4'(i)) : 8'($urandom);
				fb.eof = (i == n - 1);
				fb.drain = drain && (i == 0);
				byte_q.push_back(fb);
			end
			file_status_q.push_back(-1);
			files_built++;
			return;
		end
		case ($urandom_range(0, 5))
			0: begin w.fmt = FMT_PCM; w.bits = 16'd8; end
			1: begin w.fmt = FMT_PCM; w.bits = 16'd16; end
			2: begin w.fmt = FMT_EXT; w.bits = 16'd24; end
			3: begin w.fmt = FMT_PCM; w.bits = 16'd32; end
			4: begin w.fmt = FMT_FLOAT; w.bits = 16'd32; end
			default: begin w.fmt = 16'($urandom); w.bits = 16'($urandom); end
		endcase
		w.ch = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
		w.rate = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(1, 200000);
		w.fmt_size = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15)
			: 16 + 2 * $urandom_range(0, 2);
		w.data_size = $urandom_range(0, 30);
		w.data_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w.data_size)
			: w.data_size;
		w.junk = $urandom_range(0, 3) == 0;
		w.trailing = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		w.corrupt_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 50) : -1;
		w.cut_at = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 70) : 0;
		w.want_status = -1;
		queue_file(w, drain);
	endtask

	// Byte source: present queued bytes, idle in short bursts, hold for a drain.
	int  send_gap = 0;
	bit  byte_taken;
	file_byte_t next_byte;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.byte_in <= '0;
			in_ch.end_of_file <= 1'b0;
		end else begin
			byte_taken = in_ch.valid && in_ch.ready;
			if (byte_taken)
				predict_byte(in_ch.byte_in, in_ch.end_of_file);
			if (!in_ch.valid || byte_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (byte_q.size() == 0) begin
					in_ch.valid <= 1'b0;
				end else if (byte_q[0].drain && pending_res_q.size() != 0) begin
					// Hold the next file until every result of the previous one is out.
					in_ch.valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 2);
					in_ch.valid <= 1'b0;
				end else begin
					next_byte = byte_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.byte_in <= next_byte.b;
					in_ch.end_of_file <= next_byte.eof;
				end
			end
			quiet = byte_q.size() < 80;
		end
	end

	// Result sink: stall in short bursts, check each accepted result in order.
	int   stall_left = 0;
	res_t seen;
	res_t want;
	int   want_code;
	bit   bad;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				seen.sample_value = out_ch.sample_value;
				seen.sample_is_float = out_ch.sample_is_float;
				seen.channel_index = out_ch.channel_index;
				seen.is_status = out_ch.is_status;
				seen.status_code = out_ch.status_code;
				seen.channel_count = out_ch.channel_count;
				seen.rate_hz = out_ch.rate_hz;
				seen.frames_out = out_ch.frames_out;
				seen.last_result = out_ch.last_result;
				if (seen.is_status === 1'b1)
					statuses_seen++;
				else
					samples_seen++;
				if (pending_res_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected result %h", seen);
				end else begin
					want = pending_res_q.pop_front();
					bad = seen.sample_value !== want.sample_value ||
						seen.sample_is_float !== want.sample_is_float ||
						seen.channel_index !== want.channel_index ||
						seen.is_status !== want.is_status ||
						seen.status_code !== want.status_code ||
						seen.channel_count !== want.channel_count ||
						seen.rate_hz !== want.rate_hz ||
						seen.frames_out !== want.frames_out ||
						seen.last_result !== want.last_result;
					// Directed files also carry a status code typed in by hand.
					if (want.is_status && file_status_q.size() != 0) begin
						want_code = file_status_q.pop_front();
						if (want_code >= 0 && seen.status_code !== 3'(want_code))
							bad = 1'b1;
					end
					if (bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: result mismatch: expected val=%h flt=%b ch=%0d st=%b code=%0d cnt=%0d rate=%0d frames=%0d last=%b, got val=%h flt=%b ch=%0d st=%b code=%0d cnt=%0d rate=%0d frames=%0d last=%b",
								want.sample_value, want.sample_is_float, want.channel_index,
								want.is_status, want.status_code, want.channel_count,
								want.rate_hz, want.frames_out, want.last_result,
								seen.sample_value, seen.sample_is_float, seen.channel_index,
								seen.is_status, seen.status_code, seen.channel_count,
								seen.rate_hz, seen.frames_out, seen.last_result);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ERROR: run timed out after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.byte_in = '0;
		in_ch.end_of_file = 1'b0;
		out_ch.ready = 1'b0;
		clear_parser_state();
		foreach (directed_files[i])
			queue_file(directed_files[i], 1'b0);
		// The first random file waits for the output to drain completely.
		queue_random_file(1'b1);
		while (byte_q.size() < RANDOM_BYTES)
			queue_random_file(1'b0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// Wait for the last byte to go in and every expected result to come out.
		do
			@(posedge clk);
		while (byte_q.size() != 0 || in_ch.valid || pending_res_q.size() != 0);
		repeat (20) @(posedge clk);
		if (pending_res_q.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d expected results never arrived", pending_res_q.size());
		end
		$display("Streamed %0d files; checked %0d samples and %0d status results.",
			files_built, samples_seen, statuses_seen);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/wsp_pkg.sv
rtl/wsp_if.sv
rtl/wsp_parser.sv
rtl/wsp_out_fifo.sv
rtl/wav_stream_parser_unit.sv
tb/sv/testbench.sv
